// ===== rtl/dssp_pkg.sv =====
// ----------------------------------------------------------------------------
// dssp_pkg: shared types and constants for the decimal string split parser
// Character codes, accumulator width, parse state record and the
// multiply-by-ten helper used for every digit and scale step.
// ----------------------------------------------------------------------------
package dssp_pkg;

	localparam int ACC_WIDTH = 32;
	localparam int OUT_WIDTH = 32;
	localparam int WIDE_WIDTH = ACC_WIDTH + 4;
	localparam int RADIX = 10;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef logic [ACC_WIDTH-1:0] acc_t;

	typedef struct packed {
		acc_t int_acc;
		acc_t frac_acc;
		acc_t scale_acc;
		logic in_fraction;
		logic negative;
		logic in_digit;
		logic stopped;
		logic overflow;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		int_acc:     '0,
		frac_acc:    '0,
		scale_acc:   ACC_WIDTH'(1),
		in_fraction: 1'b0,
		negative:    1'b0,
		in_digit:    1'b0,
		stopped:     1'b0,
		overflow:    1'b0
	};

	// acc * 10 + d at full precision; the top bits show a signed overflow
	function automatic logic [WIDE_WIDTH-1:0] mul10_add(input acc_t acc, input logic [3:0] d);
		logic [WIDE_WIDTH-1:0] wide;
		wide = WIDE_WIDTH'(acc) * WIDE_WIDTH'(RADIX) + WIDE_WIDTH'(d);
		return wide;
	endfunction

	// anything at or above the sign bit means the true value passed the maximum
	function automatic logic wide_overflow(input logic [WIDE_WIDTH-1:0] wide);
		return |wide[WIDE_WIDTH-1:ACC_WIDTH-1];
	endfunction

	function automatic logic [OUT_WIDTH-1:0] to_out(input acc_t v);
		return OUT_WIDTH'($signed(v));
	endfunction

endpackage

// ===== rtl/dssp_char_step.sv =====
// ----------------------------------------------------------------------------
// dssp_char_step: one character of the parse
// Next parse state from the current state and one input character.
// ----------------------------------------------------------------------------
module dssp_char_step (
	input  dssp_pkg::parse_state_t cur,
	input  logic [7:0]             character,
	output dssp_pkg::parse_state_t nxt
);

	logic [3:0]                       digit;
	logic [dssp_pkg::WIDE_WIDTH-1:0]  int_wide;
	logic [dssp_pkg::WIDE_WIDTH-1:0]  frac_wide;
	logic [dssp_pkg::WIDE_WIDTH-1:0]  scale_wide;
	logic                             prefix_done;

	assign digit      = 4'(character - dssp_pkg::CHAR_ZERO);
	assign int_wide   = dssp_pkg::mul10_add(cur.int_acc, digit);
	assign frac_wide  = dssp_pkg::mul10_add(cur.frac_acc, digit);
	assign scale_wide = dssp_pkg::mul10_add(cur.scale_acc, 4'd0);

	always_comb begin
		nxt = cur;
		prefix_done = 1'b0;
		if (!cur.stopped) begin
			if (!cur.in_digit) begin
				// prefix phase: NUL, point and minus are consumed here
				unique case (character)
					dssp_pkg::CHAR_NUL:   nxt.stopped = 1'b1;
					dssp_pkg::CHAR_POINT: nxt.in_fraction = 1'b1;
					dssp_pkg::CHAR_MINUS: nxt.negative = 1'b1;
					default: begin
						nxt.in_digit = 1'b1;
						prefix_done = 1'b1;
					end
				endcase
			end
			if (cur.in_digit || prefix_done) begin
				case (character) inside
					dssp_pkg::CHAR_NUL:   nxt.stopped = 1'b1;
					dssp_pkg::CHAR_POINT: nxt.in_fraction = 1'b1;
					dssp_pkg::CHAR_MINUS,
					dssp_pkg::CHAR_PLUS: ;
					[dssp_pkg::CHAR_ZERO:dssp_pkg::CHAR_NINE]: begin
						if (cur.in_fraction || nxt.in_fraction) begin
							nxt.frac_acc  = frac_wide[dssp_pkg::ACC_WIDTH-1:0];
							nxt.scale_acc = scale_wide[dssp_pkg::ACC_WIDTH-1:0];
							nxt.overflow  = cur.overflow | dssp_pkg::wide_overflow(frac_wide)
							                | dssp_pkg::wide_overflow(scale_wide);
						end else begin
							nxt.int_acc  = int_wide[dssp_pkg::ACC_WIDTH-1:0];
							nxt.overflow = cur.overflow | dssp_pkg::wide_overflow(int_wide);
						end
					end
					default: nxt.stopped = 1'b1;
				endcase
			end
		end
	end

endmodule

// ===== rtl/decimal_string_split_parser_top.sv =====
// ----------------------------------------------------------------------------
// decimal_string_split_parser_top: ASCII decimal number splitter
// Streams text one character per request and returns the split value.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one ASCII character per request in s_tdata, with
//   s_tlast marking the final character of a string. Characters without
//   s_tlast give no result. The request carrying s_tlast yields one result
//   on the master channel: integer part, fraction digits and fraction scale
//   in m_tdata, and the overflow flag in m_tuser.
//   The result is valid in the cycle after the last character is taken.
//   Throughput: one character per cycle while s_tready is high, as the
//   multiply-by-ten update of the parse state is combinational; strings
//   may follow each other without gaps.
//   The result sits in an output register. While it waits, s_tready stays
//   high as long as m_tready is high; a stalled result holds the slave side
//   off only when it cannot be replaced in the same cycle.
//   Reset clears the parse state and drops m_tvalid; after a result the parse
//   state returns to its reset values for the next string.
// ----------------------------------------------------------------------------
module decimal_string_split_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] character
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [31:0] integer_part, [63:32] fraction_part,
	                               // [95:64] fraction_scale
	output logic        m_tuser    // [0] overflowed
);

	dssp_pkg::parse_state_t state_q;
	dssp_pkg::parse_state_t state_nxt;
	dssp_pkg::acc_t         int_signed;
	dssp_pkg::acc_t         frac_signed;
	logic                   s_accept;
	logic                   m_valid_q;
	logic [95:0]            m_data_q;
	logic                   m_user_q;

	dssp_char_step u_step (
		.cur       (state_q),
		.character (s_tdata),
		.nxt       (state_nxt)
	);

	assign s_tready = !m_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	// minus applies however the parse ended
	assign int_signed  = state_nxt.negative ? dssp_pkg::acc_t'(-state_nxt.int_acc)
	                                        : state_nxt.int_acc;
	assign frac_signed = state_nxt.negative ? dssp_pkg::acc_t'(-state_nxt.frac_acc)
	                                        : state_nxt.frac_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dssp_pkg::STATE_RESET;
			m_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				state_q <= s_tlast ? dssp_pkg::STATE_RESET : state_nxt;
			end
			if (s_accept && s_tlast) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && s_tlast) begin
			m_data_q <= {dssp_pkg::to_out(state_nxt.scale_acc),
			             dssp_pkg::to_out(frac_signed),
			             dssp_pkg::to_out(int_signed)};
			m_user_q <= state_nxt.overflow;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

`ifndef SYNTHESIS
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_tlast |=> m_tvalid)
		else $error("no result after last character");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_tlast |=> state_q == dssp_pkg::STATE_RESET)
		else $error("parse state not cleared after result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("slave side held off with empty output register");

	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[95:64] != '0)
		else $error("zero scale without overflow");
`endif

endmodule
